// ===== hw/rtl/rr_interval_tachogram_resampler_defines.svh =====
// Assertion macros for the tachogram resampler checker.
// Each macro expects signals named clk and arst_n in scope.
`ifndef RR_INTERVAL_TACHOGRAM_RESAMPLER_DEFINES_SVH
`define RR_INTERVAL_TACHOGRAM_RESAMPLER_DEFINES_SVH

// Same-cycle implication.
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rrts_pkg.sv =====
package rrts_pkg;

	localparam int RR_W     = 12;
	localparam int RATE_W   = 24;
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 10;
	localparam int STEP_W   = 4;
	localparam int CNT_W    = 7;
	localparam int PROD_W   = RATE_W + RR_W;
	localparam int DIVC_W   = 5;

	localparam logic [RATE_W-1:0]   RATE_NUM     = 24'd15360000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd250;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 10'd64;
	localparam logic [CNT_W-1:0]    RESULT_LIMIT = 7'd64;
	localparam logic [DIVC_W-1:0]   DIV_LAST     = DIVC_W'(RATE_W - 1);

	// datapath operations
	localparam logic [3:0] OP_NOP        = 4'd0;
	localparam logic [3:0] OP_ACCEPT     = 4'd1;
	localparam logic [3:0] OP_DIV_RATE   = 4'd2;
	localparam logic [3:0] OP_SAVE_RATE  = 4'd3;
	localparam logic [3:0] OP_MUL        = 4'd4;
	localparam logic [3:0] OP_DIV_INTERP = 4'd5;
	localparam logic [3:0] OP_CALC       = 4'd6;
	localparam logic [3:0] OP_EMIT       = 4'd7;
	localparam logic [3:0] OP_END        = 4'd8;
	localparam logic [3:0] OP_FIRST      = 4'd9;

	// jump conditions
	localparam logic [2:0] C_NEXT        = 3'd0;
	localparam logic [2:0] C_ALWAYS      = 3'd1;
	localparam logic [2:0] C_NO_ITEM     = 3'd2;
	localparam logic [2:0] C_BUSY        = 3'd3;
	localparam logic [2:0] C_NOT_STARTED = 3'd4;
	localparam logic [2:0] C_LOOP_DONE   = 3'd5;
	localparam logic [2:0] C_ON_BEAT     = 3'd6;
	localparam logic [2:0] C_OUT_FULL    = 3'd7;

	// program addresses
	localparam logic [STEP_W-1:0] ST_IDLE        = 4'd0;
	localparam logic [STEP_W-1:0] ST_RATE_START  = 4'd1;
	localparam logic [STEP_W-1:0] ST_RATE_WAIT   = 4'd2;
	localparam logic [STEP_W-1:0] ST_RATE_SAVE   = 4'd3;
	localparam logic [STEP_W-1:0] ST_TEST        = 4'd4;
	localparam logic [STEP_W-1:0] ST_MUL         = 4'd5;
	localparam logic [STEP_W-1:0] ST_INTERP      = 4'd6;
	localparam logic [STEP_W-1:0] ST_INTERP_WAIT = 4'd7;
	localparam logic [STEP_W-1:0] ST_CALC        = 4'd8;
	localparam logic [STEP_W-1:0] ST_OUT_WAIT    = 4'd9;
	localparam logic [STEP_W-1:0] ST_EMIT        = 4'd10;
	localparam logic [STEP_W-1:0] ST_END         = 4'd11;
	localparam logic [STEP_W-1:0] ST_FIRST_WAIT  = 4'd12;
	localparam logic [STEP_W-1:0] ST_FIRST       = 4'd13;

	typedef struct packed {
		logic [3:0]        op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic no_item;
		logic div_busy;
		logic not_started;
		logic loop_done;
		logic on_beat;
		logic out_full;
	} status_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		unique case (step)
			ST_IDLE:        w = '{OP_ACCEPT,     C_NO_ITEM,     ST_IDLE};
			ST_RATE_START:  w = '{OP_DIV_RATE,   C_NEXT,        ST_IDLE};
			ST_RATE_WAIT:   w = '{OP_NOP,        C_BUSY,        ST_RATE_WAIT};
			ST_RATE_SAVE:   w = '{OP_SAVE_RATE,  C_NOT_STARTED, ST_FIRST_WAIT};
			ST_TEST:        w = '{OP_NOP,        C_LOOP_DONE,   ST_END};
			ST_MUL:         w = '{OP_MUL,        C_ON_BEAT,     ST_OUT_WAIT};
			ST_INTERP:      w = '{OP_DIV_INTERP, C_NEXT,        ST_IDLE};
			ST_INTERP_WAIT: w = '{OP_NOP,        C_BUSY,        ST_INTERP_WAIT};
			ST_CALC:        w = '{OP_CALC,       C_NEXT,        ST_IDLE};
			ST_OUT_WAIT:    w = '{OP_NOP,        C_OUT_FULL,    ST_OUT_WAIT};
			ST_EMIT:        w = '{OP_EMIT,       C_ALWAYS,      ST_TEST};
			ST_END:         w = '{OP_END,        C_ALWAYS,      ST_IDLE};
			ST_FIRST_WAIT:  w = '{OP_NOP,        C_OUT_FULL,    ST_FIRST_WAIT};
			ST_FIRST:       w = '{OP_FIRST,      C_ALWAYS,      ST_IDLE};
			default:        w = '{OP_NOP,        C_ALWAYS,      ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/rr_interval_tachogram_resampler.sv =====
// RR-interval tachogram resampler.
// Input channel: in_valid/in_stall carry one rr_interval (ms) per beat.
// Output channel: out_valid/out_stall carry sample_time, heart_rate (bpm, 8 fraction
// bits) and last, which marks the final sample caused by one interval.
// cfg_wen/cfg_wdata write sample_period; write only while the block is idle.
// One interval is worked at a time by a microcoded sequencer driving a shared
// radix-2 divider. Each interval takes one rate division, plus one interpolation
// division per interpolated sample; a sample that lands on the beat skips the
// divider.
// A zero interval is accepted and dropped; the block stays ready.
// in_stall is low only while the sequencer waits for a new interval.
// Reset clears the time base and the period returns to 250 ms.
// A stalled output holds its sample; the sequencer waits until the output
// register frees up, so no sample is lost while the receiver stalls.
module rr_interval_tachogram_resampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [rrts_pkg::PERIOD_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rrts_pkg::RR_W-1:0]     rr_interval,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rrts_pkg::TIME_W-1:0]   sample_time,
	output logic [rrts_pkg::RATE_W-1:0]   heart_rate,
	output logic                          last
);
	import rrts_pkg::*;

	ucode_t            ctrl;
	status_t           status;
	logic              div_start;
	logic              div_busy;
	logic [PROD_W-1:0] div_dividend;
	logic [RR_W-1:0]   div_divisor;
	logic [RATE_W-1:0] div_quo;

	rrts_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	rrts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	rrts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.status       (status),
		.div_busy     (div_busy),
		.div_quo      (div_quo),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rr_interval  (rr_interval),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_time  (sample_time),
		.heart_rate   (heart_rate),
		.last         (last)
	);

endmodule

// ===== hw/rtl/rrts_div.sv =====
module rrts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rrts_pkg::PROD_W-1:0]   dividend,
	input  logic [rrts_pkg::RR_W-1:0]     divisor,
	output logic                          busy,
	output logic [rrts_pkg::RATE_W-1:0]   quotient
);
	import rrts_pkg::*;

	logic              busy_q;
	logic [DIVC_W-1:0] cnt_q;
	logic [RR_W-1:0]   rem_q;
	logic [RR_W-1:0]   dvs_q;
	logic [RATE_W-1:0] quo_q;
	logic [RR_W:0]     trial;
	logic              ge;
	logic [RR_W:0]     diff;

	// restoring divide, one quotient bit per cycle; upper dividend part is below divisor
	assign trial = {rem_q, quo_q[RATE_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_LAST;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:RATE_W];
			quo_q <= dividend[RATE_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RR_W-1:0] : trial[RR_W-1:0];
			quo_q <= {quo_q[RATE_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/rrts_seq.sv =====
module rrts_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  rrts_pkg::status_t status,
	output rrts_pkg::ucode_t  ctrl
);
	import rrts_pkg::*;

	logic [STEP_W-1:0] step_q;
	ucode_t            word;
	logic              jump;

	assign word = ucode_rom(step_q);

	always_comb begin
		unique case (word.cond)
			C_NEXT:        jump = 1'b0;
			C_ALWAYS:      jump = 1'b1;
			C_NO_ITEM:     jump = status.no_item;
			C_BUSY:        jump = status.div_busy;
			C_NOT_STARTED: jump = status.not_started;
			C_LOOP_DONE:   jump = status.loop_done;
			C_ON_BEAT:     jump = status.on_beat;
			C_OUT_FULL:    jump = status.out_full;
			default:       jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= jump ? word.target : step_q + 1'b1;
		end
	end

	assign ctrl = word;

endmodule

// ===== hw/rtl/rrts_dp.sv =====
module rrts_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rrts_pkg::ucode_t                ctrl,
	output rrts_pkg::status_t               status,
	input  logic                            div_busy,
	input  logic [rrts_pkg::RATE_W-1:0]     div_quo,
	output logic                            div_start,
	output logic [rrts_pkg::PROD_W-1:0]     div_dividend,
	output logic [rrts_pkg::RR_W-1:0]       div_divisor,
	input  logic                            cfg_wen,
	input  logic [rrts_pkg::PERIOD_W-1:0]   cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rrts_pkg::RR_W-1:0]       rr_interval,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rrts_pkg::TIME_W-1:0]     sample_time,
	output logic [rrts_pkg::RATE_W-1:0]     heart_rate,
	output logic                            last
);
	import rrts_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] period_eff;
	logic                started_q;
	logic [TIME_W-1:0]   last_beat_q;
	logic [RATE_W-1:0]   last_rate_q;
	logic [TIME_W-1:0]   next_q;
	logic [CNT_W-1:0]    count_q;
	logic [RR_W-1:0]     rr_q;
	logic [RATE_W-1:0]   rate_q;
	logic [PROD_W-1:0]   prod_q;
	logic                neg_q;
	logic [RATE_W-1:0]   val_q;
	logic                out_valid_q;
	logic [TIME_W-1:0]   out_time_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic                out_last_q;

	logic                op_accept;
	logic                op_emit;
	logic                op_first;
	logic                take;
	logic [TIME_W-1:0]   offset;
	logic [RATE_W:0]     diff;
	logic [RATE_W:0]     diff_neg;
	logic [RATE_W-1:0]   mag;
	logic [PROD_W-1:0]   prod_d;
	logic [RR_W:0]       reach;
	logic                last_d;

	assign period_eff = (period_q < PERIOD_MIN) ? PERIOD_MIN : period_q;
	assign op_accept  = ctrl.op == OP_ACCEPT;
	assign op_emit    = ctrl.op == OP_EMIT;
	assign op_first   = ctrl.op == OP_FIRST;
	assign take       = op_accept && in_valid && (rr_interval != '0);
	assign in_stall   = !op_accept;

	assign offset   = next_q - last_beat_q;
	assign diff     = {1'b0, rate_q} - {1'b0, last_rate_q};
	assign diff_neg = '0 - diff;
	assign mag      = diff[RATE_W] ? diff_neg[RATE_W-1:0] : diff[RATE_W-1:0];
	assign prod_d   = mag * offset[RR_W-1:0];
	assign reach    = {1'b0, offset[RR_W-1:0]} + (RR_W+1)'(period_eff);
	assign last_d   = (reach > {1'b0, rr_q}) || (count_q == RESULT_LIMIT - 1'b1);

	assign status.no_item     = !(in_valid && (rr_interval != '0));
	assign status.div_busy    = div_busy;
	assign status.not_started = !started_q;
	assign status.loop_done   = (offset == '0) || (offset > TIME_W'(rr_q)) ||
	                            (count_q == RESULT_LIMIT);
	assign status.on_beat     = offset == TIME_W'(rr_q);
	assign status.out_full    = out_valid_q && out_stall;

	assign div_start    = (ctrl.op == OP_DIV_RATE) || (ctrl.op == OP_DIV_INTERP);
	assign div_dividend = (ctrl.op == OP_DIV_RATE) ? PROD_W'(RATE_NUM) : prod_q;
	assign div_divisor  = rr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			started_q   <= 1'b0;
			last_beat_q <= '0;
			last_rate_q <= '0;
			next_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				period_q <= cfg_wdata;
			end
			if (take) begin
				count_q <= '0;
			end
			if (op_emit) begin
				next_q  <= next_q + TIME_W'(period_eff);
				count_q <= count_q + 1'b1;
			end
			if (ctrl.op == OP_END) begin
				last_beat_q <= last_beat_q + TIME_W'(rr_q);
				last_rate_q <= rate_q;
			end
			if (op_first) begin
				started_q   <= 1'b1;
				last_beat_q <= '0;
				last_rate_q <= rate_q;
				next_q      <= TIME_W'(period_eff);
			end
			if (op_emit || op_first) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rr_q <= rr_interval;
		end
		if (ctrl.op == OP_SAVE_RATE) begin
			rate_q <= div_quo;
		end
		if (ctrl.op == OP_MUL) begin
			prod_q <= prod_d;
			neg_q  <= diff[RATE_W];
			val_q  <= rate_q;
		end
		if (ctrl.op == OP_CALC) begin
			val_q <= neg_q ? last_rate_q - div_quo : last_rate_q + div_quo;
		end
		if (op_emit) begin
			out_time_q <= next_q;
			out_rate_q <= val_q;
			out_last_q <= last_d;
		end
		if (op_first) begin
			out_time_q <= '0;
			out_rate_q <= rate_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_time = out_time_q;
	assign heart_rate  = out_rate_q;
	assign last        = out_last_q;

endmodule

// ===== hw/rtl/rrts_checker.sv =====
`include "rr_interval_tachogram_resampler_defines.svh"

module rrts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wen,
	input logic [9:0]  cfg_wdata,
	input logic        in_valid,
	input logic        in_stall,
	input logic [11:0] rr_interval,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] sample_time,
	input logic [23:0] heart_rate,
	input logic        last
);

	// stalled output beat holds
	`RRTS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_time) && $stable(heart_rate) && $stable(last), "stalled output beat changed")

	// a nonzero interval occupies the sequencer
	`RRTS_ASSERT_NXT(a_busy_after_beat, in_valid && !in_stall && rr_interval != 12'd0, in_stall, "input taken while an interval is in work")

	// a zero interval is dropped without leaving idle
	`RRTS_ASSERT_NXT(a_zero_dropped, in_valid && !in_stall && rr_interval == 12'd0, !in_stall, "zero interval left the idle step")

	// interpolated rate stays within the range of 60000/rr
	`RRTS_ASSERT_IMP(a_rate_range, out_valid, heart_rate <= 24'd15360000, "heart rate out of range")

endmodule

bind rr_interval_tachogram_resampler rrts_checker u_rrts_checker (.*);

// ===== test/rr_interval_tachogram_resampler_tb.sv =====
`timescale 1ns / 1ps

module rr_interval_tachogram_resampler_tb;
	import rrts_pkg::*;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [RATE_W-1:0] rate;
		logic              is_last;
	} sample_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [PERIOD_W-1:0] cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [RR_W-1:0]     rr_interval = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [TIME_W-1:0]   sample_time;
	logic [RATE_W-1:0]   heart_rate;
	logic                last;

	// tachogram predictor state
	logic                hr_started = 1'b0;
	logic [TIME_W-1:0]   beat_time = '0;
	logic [RATE_W-1:0]   beat_rate = '0;
	logic [TIME_W-1:0]   next_time = '0;
	logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;

	sample_t         expected_samples[$];
	logic [RR_W-1:0] rr_pending[$];

	logic in_fire = 1'b0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   hold_req = 1'b0;
	bit   hold_ack = 1'b0;
	int   hold_left = 0;

	int errors = 0;
	int intervals_taken = 0;
	int zero_intervals = 0;
	int samples_checked = 0;
	int period_writes = 0;

	rr_interval_tachogram_resampler uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rr_interval(rr_interval),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_time(sample_time),
		.heart_rate (heart_rate),
		.last       (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void flag_mismatch(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endfunction

	// Interpolated samples between the previous beat and the new one.
	function automatic void predict_samples(input logic [RR_W-1:0] rr);
		logic [PERIOD_W-1:0] step_ms;
		logic [RATE_W-1:0]   rate;
		logic [RATE_W-1:0]   value;
		logic [TIME_W-1:0]   offset;
		longint              diff;
		int                  n;
		sample_t             prev;
		if (rr == '0)
			return;
		step_ms = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
		rate = RATE_W'(RATE_NUM / rr);
		if (!hr_started) begin
			hr_started = 1'b1;
			beat_time = '0;
			beat_rate = rate;
			next_time = TIME_W'(step_ms);
			prev = '{'0, rate, 1'b1};
			expected_samples.insert(expected_samples.size(), prev);
			return;
		end
		n = 0;
		prev = '0;
		offset = next_time - beat_time;
		while (n < 64 && offset != '0 && offset <= TIME_W'(rr)) begin
			if (offset == TIME_W'(rr)) begin
				value = rate;
			end else begin
				diff = longint'(rate) - longint'(beat_rate);
				value = RATE_W'(longint'(beat_rate) + diff * longint'(offset) / longint'(rr));
			end
			if (n > 0)
				expected_samples.insert(expected_samples.size(), prev);
			prev = '{next_time, value, 1'b0};
			n++;
			next_time = next_time + TIME_W'(step_ms);
			offset = next_time - beat_time;
		end
		if (n > 0) begin
			prev.is_last = 1'b1;
			expected_samples.insert(expected_samples.size(), prev);
		end
		beat_time = beat_time + TIME_W'(rr);
		beat_rate = rate;
	endfunction

	// monitor: register writes, accepted intervals, checked samples
	always @(posedge clk) begin
		sample_t want;
		if (arst_n) begin
			in_fire = in_valid && !in_stall;
			if (cfg_wen)
				period_reg = cfg_wdata;
			if (in_fire) begin
				intervals_taken++;
				if (rr_interval == '0)
					zero_intervals++;
				predict_samples(rr_interval);
			end
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					flag_mismatch($sformatf("unexpected sample t=%0d rate=%0d last=%0b",
						sample_time, heart_rate, last));
				end else begin
					want = expected_samples.pop_front();
					samples_checked++;
					if (sample_time !== want.t || heart_rate !== want.rate ||
					    last !== want.is_last)
						flag_mismatch($sformatf(
							"expected t=%0d rate=%0d last=%0b, got t=%0d rate=%0d last=%0b",
							want.t, want.rate, want.is_last,
							sample_time, heart_rate, last));
				end
			end
		end
	end

	// interval driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (rr_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rr_interval <= rr_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sample receiver back-pressure; a hold request stalls for a long stretch
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	function automatic logic [RR_W-1:0] pick_rr();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 20)
			return RR_W'($urandom_range(4095));
		else if (r < 28)
			return RR_W'($urandom_range(100, 1));
		else
			return RR_W'($urandom_range(2000, 300));
	endfunction

	task automatic queue_random(input int n);
		repeat (n) rr_pending.insert(rr_pending.size(), pick_rr());
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] v);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		period_writes++;
	endtask

	// all beats taken, all samples out, then room for a trailing silent interval
	task automatic wait_idle();
		while (rr_pending.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic long_hold();
		repeat (20) @(posedge clk);
		hold_req = ~hold_req;
	endtask

	initial begin
		logic [RR_W-1:0] opening[$];
		opening = '{12'd0, 12'd800, 12'd0, 12'd250, 12'd1, 12'd4095, 12'd2730, 12'd3000,
			12'd100, 12'd1, 12'd1500, 12'd2048, 12'd1024, 12'd512, 12'd4095, 12'd2};
		send_idle_pct = 35;
		recv_stall_pct = 58;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset period, first beat, zero beats, on-beat sample, empty interval
		foreach (opening[i]) rr_pending.insert(rr_pending.size(), opening[i]);
		wait_idle();

		// below the minimum period: longest sample bursts
		write_period(10'd0);
		rr_pending.insert(rr_pending.size(), 12'd4095);
		rr_pending.insert(rr_pending.size(), 12'd4095);
		rr_pending.insert(rr_pending.size(), 12'd63);
		rr_pending.insert(rr_pending.size(), 12'd4095);
		wait_idle();

		write_period(10'd1023);
		queue_random(40);
		wait_idle();

		write_period(10'd1000);
		queue_random(40);
		long_hold();
		wait_idle();

		send_idle_pct = 58;
		recv_stall_pct = 35;
		write_period(10'd64);
		queue_random(60);
		long_hold();
		wait_idle();

		write_period(PERIOD_W'($urandom_range(1000, 64)));
		queue_random(60);
		wait_idle();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_period(10'd63);
		queue_random(40);
		wait_idle();

		write_period(10'd250);
		queue_random(30);
		wait_idle();

		while (expected_samples.size() != 0) begin
			void'(expected_samples.pop_front());
			flag_mismatch("sample never produced");
		end

		$display("Covered %0d intervals (%0d zero) and %0d samples over %0d period writes,",
			intervals_taken, zero_intervals, samples_checked, period_writes);
		$display("including periods 0, 63, 64, 1000, 1023 and long output holds; %0d errors.",
			errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Timed out with %0d samples outstanding.", expected_samples.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_div.sv
hw/rtl/rrts_seq.sv
hw/rtl/rrts_dp.sv
hw/rtl/rr_interval_tachogram_resampler.sv
hw/rtl/rrts_checker.sv
test/rr_interval_tachogram_resampler_tb.sv
